@@ src/spd_pkg.sv @@
// ----------------------------------------------------------------------------
// Spectral peak detector package
// Shared types and constants for the divider handshake, register codes and status codes.
// ----------------------------------------------------------------------------
package spd_pkg;

	localparam int DIV_NW = 49;
	localparam int DIV_DW = 34;

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] num;
		logic [DIV_DW-1:0] den;
	} spd_div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_NW-1:0] quot;
	} spd_div_rsp_t;

	typedef enum logic [2:0] {
		CFG_THRESHOLD = 3'd0,
		CFG_INTERP    = 3'd1,
		CFG_SORT      = 3'd2,
		CFG_MAX_PEAKS = 3'd3,
		CFG_START     = 3'd4,
		CFG_LIMIT     = 3'd5,
		CFG_SCALE     = 3'd6
	} cfg_index_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_SHORT     = 2'd1,
		ST_BAD_START = 2'd2
	} status_t;

endpackage

@@ src/spd_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module spd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ src/spd_div.sv @@
// ----------------------------------------------------------------------------
// Spectral peak detector divider
// Restoring unsigned divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module spd_div
	import spd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  spd_div_req_t req,
	output spd_div_rsp_t rsp
);

	localparam int CNTW = $clog2(DIV_NW + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNTW-1:0]   cnt_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_DW:0]   shifted;
	logic [DIV_DW+1:0] trial;

	assign shifted = {rem_q, quo_q[DIV_NW-1]};
	assign trial   = {1'b0, shifted} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			den_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(DIV_NW);
				rem_q  <= '0;
				quo_q  <= req.num;
				den_q  <= req.den;
			end else if (busy_q) begin
				if (!trial[DIV_DW+1]) begin
					rem_q <= trial[DIV_DW-1:0];
					quo_q <= {quo_q[DIV_NW-2:0], 1'b1};
				end else begin
					rem_q <= shifted[DIV_DW-1:0];
					quo_q <= {quo_q[DIV_NW-2:0], 1'b0};
				end
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;

endmodule

@@ src/spectral_peak_detector.sv @@
// ----------------------------------------------------------------------------
// Spectral peak detector
// Frame store, local maximum scan, parabolic refinement and optionally sorted peak list.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle into the sample RAM until the beat marked
// last. The block then stops taking samples while it scans: each step of the
// scan reads one sample, in a read state and then a compare state. Each
// parabolic fit waits on the bit-serial divider; each peak insertion in height
// order walks the stored peaks and shifts the lower ones down; each reported
// peak is read, scaled and sent, and the send waits for the output to be free.
// A frame with an error or without peaks gives one result.
// ----------------------------------------------------------------------------
module spectral_peak_detector
	import spd_pkg::*;
#(
	parameter int MAX_SAMPLES = 4096,
	parameter int MAX_PEAKS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // sample
	input  logic        s_axis_tlast,  // last_sample
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,  // peak_position, peak_height
	output logic [2:0]  m_axis_tuser,  // peak_valid, status
	output logic        m_axis_tlast,  // last_result
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int IW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int CW = $clog2(MAX_SAMPLES + 1);
	localparam int XW = CW + 1;
	localparam int PAW = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
	localparam int PCW = $clog2(MAX_PEAKS + 1);
	localparam int PW = (IW + 18 > 34) ? IW + 18 : 34;

	typedef enum logic [5:0] {
		S_LOAD, S_CHECK, S_INIT0, S_INIT1, S_INIT2,
		S_A_RD, S_A_CMP, S_B_RD, S_B_CMP, S_C_RD, S_C_CMP,
		S_EVAL, S_EVAL_P, S_EVAL_LIM,
		S_END0, S_END1, S_END2, S_END_LAST,
		S_FIT0, S_FIT1, S_FIT2, S_FIT3, S_FIT4,
		S_ADD, S_K_RD, S_K_CMP, S_ADD_CAP, S_SH_RD, S_SH_WR,
		S_OUT0, S_O_RD, S_O_MUL, S_EMIT
	} state_t;

	logic signed [31:0] thr_q;
	logic               ie_q;
	logic               sort_q;
	logic [6:0]         maxpk_q;
	logic [11:0]        start_q;
	logic [27:0]        limit_q;
	logic [31:0]        scale_q;

	state_t             state_q;
	state_t             ret_q;
	state_t             fret_q;
	logic [CW-1:0]      s_cnt_q;
	logic [CW-1:0]      n_q;
	logic [IW-1:0]      c_q;
	logic [IW-1:0]      i_q;
	logic signed [31:0] xc_q;
	logic signed [31:0] xn_q;
	logic signed [31:0] xp_q;
	logic [PW-1:0]      lim_q;
	logic [PW-1:0]      cand_pos_q;
	logic signed [31:0] cand_h_q;
	logic [PCW-1:0]     cap_q;
	logic [PCW-1:0]     pk_cnt_q;
	logic [PCW-1:0]     k_q;
	logic [PCW-1:0]     m_q;
	logic signed [32:0] d_q;
	logic signed [33:0] den_q;
	logic               sign_q;
	logic signed [16:0] p_q;
	logic signed [67:0] mul_q;
	logic               is_peak_q;
	logic [1:0]         st_q;
	logic [31:0]        oh_q;

	logic               ov_q;
	logic [63:0]        odata_q;
	logic [2:0]         ouser_q;
	logic               olast_q;

	logic               s_we;
	logic [IW-1:0]      s_raddr;
	logic [31:0]        srd;
	logic               p_we;
	logic [PAW-1:0]     p_waddr;
	logic [63:0]        p_wdata;
	logic [PAW-1:0]     p_raddr;
	logic [63:0]        prd;

	spd_div_req_t       div_req;
	spd_div_rsp_t       div_rsp;

	logic [IW-1:0]      s_idx;
	logic               more;
	logic [31:0]        np;
	logic               precede;
	logic               mul_en;
	logic signed [33:0] mul_a;
	logic signed [33:0] mul_b;
	logic [32:0]        d_mag;
	logic [33:0]        den_mag;
	logic [15:0]        q16;
	logic signed [50:0] prod51;
	logic [50:0]        mag51;
	logic [32:0]        q2;
	logic signed [35:0] hsub;
	logic signed [35:0] h36;
	logic signed [31:0] hsat;
	logic signed [PW:0] ps;
	logic [63:0]        rnd;
	logic [31:0]        pos_out;
	logic               last_k;
	logic               emit_go;
	logic [31:0]        scale_eff;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == S_LOAD);
	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata  = odata_q;
	assign m_axis_tuser  = ouser_q;
	assign m_axis_tlast  = olast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= '0;
			ie_q    <= 1'b1;
			sort_q  <= 1'b0;
			maxpk_q <= '0;
			start_q <= '0;
			limit_q <= '0;
			scale_q <= 32'h0001_0000;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_THRESHOLD: thr_q   <= cfg_data;
				CFG_INTERP:    ie_q    <= cfg_data[0];
				CFG_SORT:      sort_q  <= cfg_data[0];
				CFG_MAX_PEAKS: maxpk_q <= cfg_data[6:0];
				CFG_START:     start_q <= cfg_data[11:0];
				CFG_LIMIT:     limit_q <= cfg_data[27:0];
				CFG_SCALE:     scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	spd_ram #(.WIDTH(32), .DEPTH(MAX_SAMPLES), .AW(IW)) u_sample_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_cnt_q[IW-1:0]),
		.wdata (s_axis_tdata),
		.raddr (s_raddr),
		.rdata (srd)
	);

	spd_ram #(.WIDTH(64), .DEPTH(MAX_PEAKS), .AW(PAW)) u_peak_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.raddr (p_raddr),
		.rdata (prd)
	);

	spd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		s_idx   = IW'(start_q);
		more    = (XW'(c_q) + XW'(2)) < XW'(n_q);
		s_we    = (state_q == S_LOAD) && s_axis_tvalid && (s_cnt_q < CW'(MAX_SAMPLES));

		unique case (state_q)
			S_INIT0:                  s_raddr = s_idx;
			S_INIT1:                  s_raddr = s_idx + IW'(1);
			S_END0:                   s_raddr = c_q - IW'(1);
			S_EVAL:                   s_raddr = i_q - IW'(1);
			S_A_RD, S_B_RD, S_C_RD,
			S_END1:                   s_raddr = c_q + IW'(1);
			default:                  s_raddr = c_q;
		endcase

		np = (|cand_pos_q[PW-1:32]) ? 32'hFFFF_FFFF : cand_pos_q[31:0];
		precede = !sort_q || ($signed(prd[63:32]) > cand_h_q) ||
			(($signed(prd[63:32]) == cand_h_q) && (prd[31:0] <= np));

		p_we    = 1'b0;
		p_waddr = k_q[PAW-1:0];
		p_wdata = {cand_h_q, np};
		if (state_q == S_SH_WR) begin
			p_we    = 1'b1;
			p_waddr = m_q[PAW-1:0];
			p_wdata = prd;
		end else if (state_q == S_SH_RD && !(m_q > k_q)) begin
			p_we = 1'b1;
		end
		if (state_q == S_SH_RD) begin
			p_raddr = PAW'(m_q - PCW'(1));
		end else begin
			p_raddr = k_q[PAW-1:0];
		end

		d_mag   = d_q[32] ? 33'(-d_q) : 33'(d_q);
		den_mag = den_q[33] ? 34'(-den_q) : 34'(den_q);
		div_req.start = (state_q == S_FIT1);
		div_req.num   = DIV_NW'({d_mag, 15'b0}) + DIV_NW'(den_mag >> 1);
		div_req.den   = den_mag;
		q16 = div_rsp.quot[15:0];

		scale_eff = (scale_q == 32'd0) ? 32'h0001_0000 : scale_q;
		mul_en = (state_q == S_FIT3) || (state_q == S_O_MUL);
		if (state_q == S_O_MUL) begin
			mul_a = $signed({2'b00, prd[31:0]});
			mul_b = $signed({2'b00, scale_eff});
		end else begin
			mul_a = {d_q[32], d_q};
			mul_b = {{17{p_q[16]}}, p_q};
		end

		prod51 = mul_q[50:0];
		mag51  = prod51[50] ? 51'(-prod51) : 51'(prod51);
		q2     = 33'((mag51 + 51'd131072) >> 18);
		hsub   = prod51[50] ? -$signed({3'b000, q2}) : $signed({3'b000, q2});
		h36    = $signed({{4{xc_q[31]}}, xc_q}) - hsub;
		if (h36 > 36'sd2147483647) begin
			hsat = 32'sh7FFF_FFFF;
		end else if (h36 < -36'sd2147483648) begin
			hsat = 32'sh8000_0000;
		end else begin
			hsat = h36[31:0];
		end
		ps = $signed({1'b0, (PW'(c_q) << 16)}) + $signed({{(PW-16){p_q[16]}}, p_q});

		rnd     = mul_q[63:0] + 64'd32768;
		pos_out = (|rnd[63:48]) ? 32'hFFFF_FFFF : rnd[47:16];
		last_k  = (k_q + PCW'(1)) == pk_cnt_q;
		emit_go = (state_q == S_EMIT) && (!ov_q || m_axis_tready);
	end

	always_ff @(posedge clk) begin
		if (mul_en) begin
			mul_q <= mul_a * mul_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q    <= 1'b0;
			odata_q <= '0;
			ouser_q <= '0;
			olast_q <= 1'b0;
		end else if (emit_go) begin
			ov_q <= 1'b1;
			if (is_peak_q) begin
				odata_q <= {oh_q, pos_out};
				olast_q <= last_k;
			end else begin
				odata_q <= '0;
				olast_q <= 1'b1;
			end
			ouser_q <= {st_q, is_peak_q};
		end else if (m_axis_tready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD;
			ret_q      <= S_LOAD;
			fret_q     <= S_LOAD;
			s_cnt_q    <= '0;
			n_q        <= '0;
			c_q        <= '0;
			i_q        <= '0;
			xc_q       <= '0;
			xn_q       <= '0;
			xp_q       <= '0;
			lim_q      <= '0;
			cand_pos_q <= '0;
			cand_h_q   <= '0;
			cap_q      <= '0;
			pk_cnt_q   <= '0;
			k_q        <= '0;
			m_q        <= '0;
			d_q        <= '0;
			den_q      <= '0;
			sign_q     <= 1'b0;
			p_q        <= '0;
			is_peak_q  <= 1'b0;
			st_q       <= ST_OK;
			oh_q       <= '0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (s_axis_tvalid) begin
						if (s_cnt_q < CW'(MAX_SAMPLES)) begin
							s_cnt_q <= s_cnt_q + CW'(1);
						end
						if (s_axis_tlast) begin
							n_q <= (s_cnt_q < CW'(MAX_SAMPLES)) ? s_cnt_q + CW'(1) : s_cnt_q;
							s_cnt_q <= '0;
							state_q <= S_CHECK;
						end
					end
				end
				S_CHECK: begin
					is_peak_q <= 1'b0;
					if (n_q < CW'(2)) begin
						st_q    <= ST_SHORT;
						state_q <= S_EMIT;
					end else if ((32'(start_q) >= 32'(n_q) - 32'd1) ||
						(start_q != '0 && limit_q != '0 && {start_q, 16'b0} >= limit_q)) begin
						st_q    <= ST_BAD_START;
						state_q <= S_EMIT;
					end else begin
						st_q     <= ST_OK;
						cap_q    <= (maxpk_q == '0 || maxpk_q > 7'(MAX_PEAKS)) ?
							PCW'(MAX_PEAKS) : PCW'(maxpk_q);
						pk_cnt_q <= '0;
						lim_q    <= (limit_q == '0) ? ((PW'(n_q) - PW'(1)) << 16) : PW'(limit_q);
						state_q  <= S_INIT0;
					end
				end
				S_INIT0: state_q <= S_INIT1;
				S_INIT1: begin
					xc_q    <= srd;
					c_q     <= s_idx;
					state_q <= S_INIT2;
				end
				S_INIT2: begin
					xn_q <= srd;
					if (xc_q > $signed(srd) && xc_q > thr_q) begin
						cand_pos_q <= PW'(s_idx) << 16;
						cand_h_q   <= xc_q;
						ret_q      <= S_A_RD;
						state_q    <= S_ADD;
					end else begin
						state_q <= S_A_RD;
					end
				end
				S_A_RD: state_q <= more ? S_A_CMP : S_END0;
				S_A_CMP: begin
					c_q     <= c_q + IW'(1);
					xc_q    <= srd;
					state_q <= (xc_q >= $signed(srd)) ? S_A_RD : S_B_RD;
				end
				S_B_RD: state_q <= more ? S_B_CMP : S_END0;
				S_B_CMP: begin
					if (xc_q < $signed(srd)) begin
						c_q     <= c_q + IW'(1);
						xc_q    <= srd;
						state_q <= S_B_RD;
					end else begin
						i_q     <= c_q;
						state_q <= S_C_RD;
					end
				end
				S_C_RD: state_q <= S_C_CMP;
				S_C_CMP: begin
					if (more && xc_q == $signed(srd)) begin
						c_q     <= c_q + IW'(1);
						state_q <= S_C_RD;
					end else begin
						xn_q    <= srd;
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (xc_q > xn_q && xc_q > thr_q) begin
						cand_h_q <= xc_q;
						if (c_q != i_q) begin
							cand_pos_q <= ie_q ? ((PW'(i_q) + PW'(c_q)) << 15) : (PW'(i_q) << 16);
							state_q    <= S_EVAL_LIM;
						end else if (ie_q && i_q != '0) begin
							state_q <= S_EVAL_P;
						end else begin
							cand_pos_q <= PW'(c_q) << 16;
							state_q    <= S_EVAL_LIM;
						end
					end else begin
						state_q <= S_A_RD;
					end
				end
				S_EVAL_P: begin
					xp_q    <= srd;
					fret_q  <= S_EVAL_LIM;
					state_q <= S_FIT0;
				end
				S_EVAL_LIM: begin
					if (cand_pos_q > lim_q) begin
						state_q <= S_OUT0;
					end else begin
						ret_q   <= S_A_RD;
						state_q <= S_ADD;
					end
				end
				S_END0: state_q <= S_END1;
				S_END1: begin
					xp_q    <= srd;
					state_q <= S_END2;
				end
				S_END2: begin
					xn_q  <= srd;
					ret_q <= S_END_LAST;
					if (c_q != '0 && xp_q < xc_q && $signed(srd) < xc_q && xc_q > thr_q) begin
						if (ie_q) begin
							fret_q  <= S_ADD;
							state_q <= S_FIT0;
						end else begin
							cand_pos_q <= PW'(c_q) << 16;
							cand_h_q   <= xc_q;
							state_q    <= S_ADD;
						end
					end else begin
						state_q <= S_END_LAST;
					end
				end
				S_END_LAST: begin
					if (lim_q > ((PW'(n_q) - PW'(2)) << 16) &&
						lim_q <= ((PW'(n_q) - PW'(1)) << 16) &&
						xn_q > xc_q && xn_q > thr_q) begin
						cand_pos_q <= (PW'(n_q) - PW'(1)) << 16;
						cand_h_q   <= xn_q;
						ret_q      <= S_OUT0;
						state_q    <= S_ADD;
					end else begin
						state_q <= S_OUT0;
					end
				end
				S_FIT0: begin
					d_q     <= {xp_q[31], xp_q} - {xn_q[31], xn_q};
					den_q   <= {{2{xp_q[31]}}, xp_q} - {xc_q[31], xc_q, 1'b0} +
						{{2{xn_q[31]}}, xn_q};
					state_q <= S_FIT1;
				end
				S_FIT1: begin
					sign_q  <= d_q[32] ^ den_q[33];
					state_q <= S_FIT2;
				end
				S_FIT2: begin
					if (div_rsp.done) begin
						if (den_q == '0) begin
							p_q <= '0;
						end else if (sign_q) begin
							p_q <= -$signed({1'b0, q16});
						end else begin
							p_q <= $signed({1'b0, q16});
						end
						state_q <= S_FIT3;
					end
				end
				S_FIT3: state_q <= S_FIT4;
				S_FIT4: begin
					cand_h_q   <= hsat;
					cand_pos_q <= ps[PW] ? '0 : ps[PW-1:0];
					state_q    <= fret_q;
				end
				S_ADD: begin
					if (sort_q) begin
						k_q     <= '0;
						state_q <= S_K_RD;
					end else begin
						k_q     <= pk_cnt_q;
						state_q <= S_ADD_CAP;
					end
				end
				S_K_RD: state_q <= (k_q < pk_cnt_q) ? S_K_CMP : S_ADD_CAP;
				S_K_CMP: begin
					if (precede) begin
						k_q     <= k_q + PCW'(1);
						state_q <= S_K_RD;
					end else begin
						state_q <= S_ADD_CAP;
					end
				end
				S_ADD_CAP: begin
					if (k_q >= cap_q) begin
						state_q <= ret_q;
					end else begin
						m_q     <= (pk_cnt_q < cap_q) ? pk_cnt_q : cap_q - PCW'(1);
						state_q <= S_SH_RD;
					end
				end
				S_SH_RD: begin
					if (m_q > k_q) begin
						state_q <= S_SH_WR;
					end else begin
						if (pk_cnt_q < cap_q) begin
							pk_cnt_q <= pk_cnt_q + PCW'(1);
						end
						state_q <= ret_q;
					end
				end
				S_SH_WR: begin
					m_q     <= m_q - PCW'(1);
					state_q <= S_SH_RD;
				end
				S_OUT0: begin
					st_q <= ST_OK;
					k_q  <= '0;
					if (pk_cnt_q == '0) begin
						is_peak_q <= 1'b0;
						state_q   <= S_EMIT;
					end else begin
						state_q <= S_O_RD;
					end
				end
				S_O_RD: state_q <= S_O_MUL;
				S_O_MUL: begin
					oh_q      <= prd[63:32];
					is_peak_q <= 1'b1;
					state_q   <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_go) begin
						if (!is_peak_q || last_k) begin
							state_q <= S_LOAD;
						end else begin
							k_q     <= k_q + PCW'(1);
							state_q <= S_O_RD;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

endmodule
